// ===== src/spq_pkg.sv =====
package spq_pkg;

  // Default sizes of the queue.
  localparam int CapacityDef     = 64;
  localparam int PriorityBitsDef = 16;
  localparam int IdBitsDef       = 16;

  // Width of the request kind and of the result status.
  localparam int OpBits     = 2;
  localparam int StatusBits = 3;

  // Request kinds carried on in_tuser.
  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 2'd0,
    OP_SERVE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Result status carried on out_tuser.
  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic serve;
  } cell_ctrl_t;

endpackage

// ===== src/stable_priority_queue.sv =====
// A request accepted at one clock edge has its result on out_* right after that edge, held in
// the result register.
// Throughput: one request per cycle while the result register is free or out_tready is high;
// insert and serve update every cell of the sorted chain together, clear only resets the count.
// Reset (synchronous, rst_n low) empties the queue and the output register at once;
// entry storage is not cleared and no clearing pass is needed.
module stable_priority_queue #(
  parameter int CAPACITY      = spq_pkg::CapacityDef,
  parameter int PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int ID_BITS       = spq_pkg::IdBitsDef,
  localparam int CNT_W        = $clog2(CAPACITY + 1),
  localparam int IN_DW        = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_DW       = ((ID_BITS + PRIORITY_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: item_id, priority_req, zero padding.
  input  logic [IN_DW-1:0]               in_tdata,
  // Fields from bit 0: op.
  input  logic [spq_pkg::OpBits-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: served_id, served_priority, occupancy, zero padding.
  output logic [OUT_DW-1:0]              out_tdata,
  // Fields from bit 0: status.
  output logic [spq_pkg::StatusBits-1:0] out_tuser
);

  logic                     accept;
  spq_pkg::op_t             op;
  logic [ID_BITS-1:0]       new_id;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic                     full, empty;
  spq_pkg::cell_ctrl_t      ctrl;

  logic [CNT_W-1:0]         count_r, count_nxt;
  spq_pkg::status_t         status;

  logic                     out_valid_r;
  spq_pkg::status_t         out_status_r;
  logic [ID_BITS-1:0]       out_id_r;
  logic [PRIORITY_BITS-1:0] out_prio_r;
  logic [CNT_W-1:0]         out_occ_r;

  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_keep;
  logic [ID_BITS-1:0]       cell_id   [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];

  // Input side: a request is taken whenever the result register is free or drains.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = spq_pkg::op_t'(in_tuser);
  assign new_id    = in_tdata[ID_BITS-1:0];
  assign new_prio  = in_tdata[ID_BITS +: PRIORITY_BITS];

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Decode the request into the chain command, the new fill count and the status.
  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    status    = spq_pkg::ST_CLEARED;
    unique case (op)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_nxt   = count_r + CNT_W'(1);
          status      = spq_pkg::ST_INSERTED;
        end
      end
      spq_pkg::OP_SERVE: begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.serve = accept;
          count_nxt  = count_r - CNT_W'(1);
          status     = spq_pkg::ST_SERVED;
        end
      end
      default: begin
        count_nxt = '0;
        status    = spq_pkg::ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Sorted chain: cell 0 holds the head, each cell trades with its neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_keep;
    logic [ID_BITS-1:0]       left_id,  right_id;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;

    assign cell_valid[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_id   = new_id;
      assign left_prio = new_prio;
    end else begin : g_body
      assign left_keep = cell_keep[i-1];
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .ID_BITS      (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid_i    (cell_valid[i]),
      .left_keep_i(left_keep),
      .new_id     (new_id),
      .new_prio   (new_prio),
      .left_id    (left_id),
      .left_prio  (left_prio),
      .right_id   (right_id),
      .right_prio (right_prio),
      .keep_o     (cell_keep[i]),
      .id_o       (cell_id[i]),
      .prio_o     (cell_prio[i])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_occ_r    <= count_nxt;
      if (status == spq_pkg::ST_SERVED) begin
        out_id_r   <= cell_id[0];
        out_prio_r <= cell_prio[0];
      end else begin
        out_id_r   <= '0;
        out_prio_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DW - ID_BITS - PRIORITY_BITS - CNT_W){1'b0}},
                       out_occ_r, out_prio_r, out_id_r};

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A successful insert grows the queue by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue by one");

  // Every accepted request leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // Served fields stay zero for every status other than served.
  a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != spq_pkg::ST_SERVED) |-> (out_id_r == '0)
      && (out_prio_r == '0))
    else $error("served fields nonzero without a serve");

endmodule

// ===== src/spq_cell.sv =====
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int ID_BITS       = spq_pkg::IdBitsDef
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  logic                     valid_i,
  input  logic                     left_keep_i,
  input  logic [ID_BITS-1:0]       new_id,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [ID_BITS-1:0]       left_id,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [ID_BITS-1:0]       right_id,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic                     keep_o,
  output logic [ID_BITS-1:0]       id_o,
  output logic [PRIORITY_BITS-1:0] prio_o
);

  logic [ID_BITS-1:0]       id_r,   id_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // A held entry stays in place on insert when it ranks at or above the new
  // one, so equal priorities keep their arrival order.
  assign keep_o = valid_i && (prio_r >= new_prio);

  // Insert: keep, take the new entry at the boundary, or shift down from the
  // left. Serve: shift up from the right.
  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    if (ctrl.insert && !keep_o) begin
      if (left_keep_i) begin
        id_nxt   = new_id;
        prio_nxt = new_prio;
      end else begin
        id_nxt   = left_id;
        prio_nxt = left_prio;
      end
    end else if (ctrl.serve) begin
      id_nxt   = right_id;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign id_o   = id_r;
  assign prio_o = prio_r;

endmodule

// ===== bench/tb_stable_priority_queue.sv =====
module tb_stable_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the instance under test, taken from the package defaults.
  localparam int QUEUE_DEPTH = spq_pkg::CapacityDef;
  localparam int ID_W        = spq_pkg::IdBitsDef;
  localparam int PRIO_W      = spq_pkg::PriorityBitsDef;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DW       = ((ID_W + PRIO_W + 7) / 8) * 8;
  localparam int OUT_DW      = ((ID_W + PRIO_W + CNT_W + 7) / 8) * 8;

  // The op code left unused by the package; the queue treats it as a clear.
  localparam logic [spq_pkg::OpBits-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 260;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } queue_entry_t;

  typedef struct packed {
    spq_pkg::status_t  status;
    logic [ID_W-1:0]   served_id;
    logic [PRIO_W-1:0] served_prio;
    logic [CNT_W-1:0]  occupancy;
  } queue_result_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [IN_DW-1:0]               in_tdata   = '0;
  logic [spq_pkg::OpBits-1:0]     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [OUT_DW-1:0]              out_tdata;
  logic [spq_pkg::StatusBits-1:0] out_tuser;

  // Shadow copy of the queue contents, in serve order.
  queue_entry_t  held_entries[$];
  // Results predicted for accepted requests, oldest first.
  queue_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  stable_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Applies one request to the shadow queue and returns the result it must produce.
  function automatic queue_result_t predict_queue(input logic [spq_pkg::OpBits-1:0] op,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    queue_entry_t  fresh;
    queue_entry_t  head;
    int            pos;
    res = '0;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (held_entries.size() >= QUEUE_DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // A new entry goes behind every held entry of equal or higher priority.
          pos = 0;
          while (pos < held_entries.size() && held_entries[pos].prio >= prio) pos++;
          fresh.id   = id;
          fresh.prio = prio;
          held_entries.insert(pos, fresh);
          res.status = spq_pkg::ST_INSERTED;
        end
      end
      spq_pkg::OP_SERVE: begin
        if (held_entries.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          head            = held_entries.pop_front();
          res.served_id   = head.id;
          res.served_prio = head.prio;
          res.status      = spq_pkg::ST_SERVED;
        end
      end
      default: begin
        held_entries.delete();
        res.status = spq_pkg::ST_CLEARED;
      end
    endcase
    res.occupancy = CNT_W'(held_entries.size());
    return res;
  endfunction

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = spq_pkg::status_t'(out_tuser);
      got.served_id   = out_tdata[ID_W-1:0];
      got.served_prio = out_tdata[ID_W +: PRIO_W];
      got.occupancy   = out_tdata[ID_W + PRIO_W +: CNT_W];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf(
          "result with no request outstanding: status %0d id %h prio %h occ %0d",
          got.status, got.served_id, got.served_prio, got.occupancy));
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          note_mismatch($sformatf(
            "expected status %0d id %h prio %h occ %0d, got status %0d id %h prio %h occ %0d",
            want.status, want.served_id, want.served_prio, want.occupancy,
            got.status, got.served_id, got.served_prio, got.occupancy));
        end
      end
    end
  end

  // Sends one request and records its predicted result once it is accepted.
  task automatic send_request(input logic [spq_pkg::OpBits-1:0] op,
                              input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DW'({prio, id});
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_queue(op, id, prio));
  endtask

  // Empty serve, field extremes, equal-priority order and both clear codes.
  task automatic test_directed_cases();
    send_request(spq_pkg::OP_SERVE,  16'h0000, 16'h0000);
    send_request(spq_pkg::OP_INSERT, 16'hffff, 16'h0000);
    send_request(spq_pkg::OP_INSERT, 16'h0000, 16'hffff);
    send_request(spq_pkg::OP_INSERT, 16'h1111, 16'h0005);
    send_request(spq_pkg::OP_INSERT, 16'h2222, 16'h0005);
    send_request(spq_pkg::OP_INSERT, 16'h3333, 16'h0005);
    send_request(spq_pkg::OP_INSERT, 16'haaaa, 16'hffff);
    send_request(spq_pkg::OP_SERVE,  16'hffff, 16'hffff);
    send_request(spq_pkg::OP_SERVE,  16'h0000, 16'h0000);
    send_request(spq_pkg::OP_SERVE,  16'h5a5a, 16'ha5a5);
    send_request(spq_pkg::OP_INSERT, 16'h4444, 16'h0005);
    send_request(spq_pkg::OP_SERVE,  16'h0000, 16'h0000);
    send_request(OP_UNUSED,          16'hffff, 16'hffff);
    send_request(spq_pkg::OP_SERVE,  16'h0000, 16'h0000);
    send_request(spq_pkg::OP_INSERT, 16'h5555, 16'h7fff);
    send_request(spq_pkg::OP_INSERT, 16'h6666, 16'h8000);
    send_request(spq_pkg::OP_CLEAR,  16'h0000, 16'h0000);
    send_request(spq_pkg::OP_SERVE,  16'h0000, 16'h0000);
    send_request(spq_pkg::OP_CLEAR,  16'h0000, 16'h0000);
  endtask

  // Fills the queue, overfills it, then drains it past empty.
  task automatic test_full_queue();
    send_request(spq_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
    repeat (QUEUE_DEPTH + 3) begin
      send_request(spq_pkg::OP_INSERT, 16'($urandom), 16'($urandom_range(15)));
    end
    repeat (QUEUE_DEPTH + 2) begin
      send_request(spq_pkg::OP_SERVE, 16'($urandom), 16'($urandom));
    end
  endtask

  // Random traffic in bursts that lean toward filling, holding or draining the queue.
  task automatic test_random_traffic(input int n_requests);
    int                         insert_pct;
    int                         burst_left;
    int                         roll;
    logic [spq_pkg::OpBits-1:0] op;
    logic [PRIO_W-1:0]          prio;
    burst_left = 0;
    insert_pct = 50;
    repeat (n_requests) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(150, 20);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      burst_left--;
      roll = $urandom_range(99);
      if (roll == 0) begin
        op = $urandom_range(1) ? spq_pkg::OP_CLEAR : OP_UNUSED;
      end else if (roll <= insert_pct) begin
        op = spq_pkg::OP_INSERT;
      end else begin
        op = spq_pkg::OP_SERVE;
      end
      // Narrow priority ranges make ties common; the rest spans the whole field.
      case ($urandom_range(3))
        0:       prio = PRIO_W'($urandom_range(7));
        1:       prio = '1 - PRIO_W'($urandom_range(7));
        default: prio = PRIO_W'($urandom);
      endcase
      send_request(op, ID_W'($urandom), prio);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_full_queue();

    // Random traffic under each idling pattern.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_REQUESTS);
    send_idle_pct  = 82;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_REQUESTS);
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    test_random_traffic(RANDOM_REQUESTS);
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    test_random_traffic(RANDOM_REQUESTS);

    // Let every outstanding result arrive, then watch for strays.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
